@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// Needs signals clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define LPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/lpr_pkg.sv @@
// Types, codes and helper functions of the longest prefix router.
// No dependencies; used by every module of the router except lpr_ram.
package lpr_pkg;

  localparam logic        CMD_ADD   = 1'b0;
  localparam logic        CMD_ROUTE = 1'b1;

  localparam logic [2:0]  ST_FORWARDED    = 3'd0;
  localparam logic [2:0]  ST_DROP_TTL     = 3'd1;
  localparam logic [2:0]  ST_DROP_NOROUTE = 3'd2;
  localparam logic [2:0]  ST_ADDED        = 3'd3;
  localparam logic [2:0]  ST_FULL         = 3'd4;

  localparam logic [5:0]  PREFIX_FULL = 6'd32;
  localparam logic [31:0] MASK_ALL    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_DROP_TTL,
    KIND_LOOKUP
  } kind_e;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        gw_valid;
    logic [31:0] gw;
    logic [2:0]  port;
  } route_entry_t;

  typedef struct packed {
    kind_e        kind;
    route_entry_t entry;
    logic [31:0]  dest;
    logic [7:0]   ttl_dec;
  } job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  out_port;
    logic [31:0] hop_addr;
    logic [7:0]  new_hops_left;
  } result_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = '0;
    end else if (len >= PREFIX_FULL) begin
      m = MASK_ALL;
    end else begin
      m = MASK_ALL << (PREFIX_FULL - len);
    end
    return m;
  endfunction

endpackage

@@ rtl/core/lpr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lpr_ram #(
  parameter int WIDTH = 74,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/lpr_front.sv @@
// Front end of the router: unpacks an input word and classifies it into a job.
// Depends on lpr_pkg.
module lpr_front (
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [119:0]      s_tdata_i,
  input  logic              s_tuser_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output lpr_pkg::job_t     job_o
);

  logic [5:0] len_raw;
  logic [7:0] hops;

  assign len_raw = s_tdata_i[37:32];
  assign hops    = s_tdata_i[113:106];

  always_comb begin
    job_o                = '0;
    job_o.entry.prefix   = s_tdata_i[31:0];
    // Lengths above a full address match like a full address.
    job_o.entry.len      = (len_raw > lpr_pkg::PREFIX_FULL) ? lpr_pkg::PREFIX_FULL : len_raw;
    job_o.entry.gw_valid = s_tdata_i[38];
    job_o.entry.gw       = s_tdata_i[70:39];
    job_o.entry.port     = s_tdata_i[73:71];
    job_o.dest           = s_tdata_i[105:74];
    job_o.ttl_dec        = hops - 8'd1;
    if (s_tuser_i == lpr_pkg::CMD_ADD) begin
      job_o.kind = lpr_pkg::KIND_ADD;
    end else if (hops <= 8'd1) begin
      job_o.kind = lpr_pkg::KIND_DROP_TTL;
    end else begin
      job_o.kind = lpr_pkg::KIND_LOOKUP;
    end
  end

  assign job_valid_o = s_tvalid_i;
  assign s_tready_o  = job_ready_i;

endmodule

@@ rtl/core/lpr_queue.sv @@
// Two-entry job queue between the front end and the table engine.
// Depends on lpr_pkg.
module lpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  lpr_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output lpr_pkg::job_t pop_data_o
);

  lpr_pkg::job_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/lpr_back.sv @@
// Table engine: stores routes, scans the table one entry per cycle for the
// longest match and holds the result word. Depends on lpr_pkg and lpr_ram.
module lpr_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_PORTS   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  lpr_pkg::job_t    job_i,
  output logic             job_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output lpr_pkg::result_t res_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(lpr_pkg::route_entry_t);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  found_q, found_d;
  lpr_pkg::route_entry_t best_q, best_d;
  logic [31:0]           dest_q, dest_d;
  logic [7:0]            ttl_q, ttl_d;
  lpr_pkg::result_t      res_q, res_d;
  lpr_pkg::result_t      out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  wr_en;
  logic [EW-1:0]         rd_data;
  lpr_pkg::route_entry_t rd_entry;
  logic                  hit;
  logic                  out_free;

  lpr_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (job_i.entry),
    .rd_addr_i (idx_d),
    .rd_data_o (rd_data)
  );

  assign rd_entry = lpr_pkg::route_entry_t'(rd_data);
  assign hit      = ((rd_entry.prefix ^ dest_q) & lpr_pkg::prefix_mask(rd_entry.len)) == 32'd0;
  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_d      = best_q;
    dest_d      = dest_q;
    ttl_d       = ttl_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    job_pop_o   = 1'b0;
    wr_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          dest_d    = job_i.dest;
          ttl_d     = job_i.ttl_dec;
          res_d     = '0;
          state_d   = S_HOLD;
          unique case (job_i.kind)
            lpr_pkg::KIND_ADD: begin
              if (count_q == FULL_COUNT) begin
                res_d.status = lpr_pkg::ST_FULL;
              end else begin
                wr_en        = 1'b1;
                count_d      = count_q + CW'(1);
                res_d.status = lpr_pkg::ST_ADDED;
              end
            end
            lpr_pkg::KIND_DROP_TTL: begin
              res_d.status = lpr_pkg::ST_DROP_TTL;
            end
            lpr_pkg::KIND_LOOKUP: begin
              if (count_q == '0) begin
                res_d.status = lpr_pkg::ST_DROP_NOROUTE;
              end else begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_d.status = lpr_pkg::ST_DROP_NOROUTE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Strictly longer wins, so the earliest entry keeps a tie.
        if (hit && (!found_q || rd_entry.len > best_q.len)) begin
          found_d = 1'b1;
          best_d  = rd_entry;
        end
        if (CW'(idx_q) + CW'(1) == count_q) begin
          res_d = '0;
          if (!found_d || (32'(best_d.port) >= 32'(NUM_PORTS))) begin
            res_d.status = lpr_pkg::ST_DROP_NOROUTE;
          end else begin
            res_d.status        = lpr_pkg::ST_FORWARDED;
            res_d.out_port      = best_d.port;
            res_d.hop_addr      = best_d.gw_valid ? best_d.gw : dest_q;
            res_d.new_hops_left = ttl_q;
          end
          state_d = S_HOLD;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    dest_q <= dest_d;
    ttl_q  <= ttl_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ rtl/core/ipv4_longest_prefix_router.sv @@
// IPv4 longest prefix match router: route table with add and lookup commands.
// An add or TTL drop passes through the job queue, the engine's result register
// and its output register; a lookup also scans the table, one RAM entry per cycle,
// before its result is registered. The engine takes one job at a time.
// Reset (rst_ni, asynchronous, active low) empties the table and the job queue.
// Depends on lpr_pkg, lpr_front, lpr_queue, lpr_back and lpr_ram.
module ipv4_longest_prefix_router #(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_PORTS   = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input word.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // prefix_value[31:0], prefix_bits[37:32], has_gateway[38], gateway_addr[70:39],
  // port_index[73:71], dest_addr[105:74], hops_left[113:106], zero pad[119:114]
  input  logic [119:0] s_axis_tdata_i,
  // command[0]: 0 adds a route, 1 routes a datagram
  input  logic         s_axis_tuser_i,
  // Result word.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_port[2:0], hop_addr[34:3], new_hops_left[42:35], zero pad[47:43]
  output logic [47:0]  m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]   m_axis_tuser_o
);

  // The front end turns each input word into a job: an add, a TTL drop that
  // needs no table access, or a lookup. The TTL check and the decrement are
  // done here, not in the engine.
  logic             front_valid;
  logic             front_ready;
  lpr_pkg::job_t    front_job;

  // The queue lets the front end keep accepting words while the engine is
  // busy scanning the table.
  logic             job_valid;
  logic             job_pop;
  lpr_pkg::job_t    job;

  lpr_pkg::result_t res;

  lpr_front u_front (
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  lpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_pop),
    .pop_data_o   (job)
  );

  // The engine appends routes at the fill count and, for a lookup, walks the
  // stored entries in order, keeping the first of the longest matches. Its
  // output register holds a finished word while the engine takes the next job.
  lpr_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_PORTS   (NUM_PORTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Words that are not forwarded carry all-zero data fields.
  assign m_axis_tdata_o = {5'd0, res.new_hops_left, res.hop_addr, res.out_port};
  assign m_axis_tuser_o = res.status;

endmodule

@@ rtl/core/lpr_checker.sv @@
// Port-level checks of the router's result stream, bound to the top level.
// Depends on lpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [47:0] m_tdata_i,
  input logic [2:0]  m_tuser_i
);

  `LPR_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |-> !m_tvalid_i, "result word during reset")
  `LPR_ASSERT(a_word_held, m_tvalid_i && !m_tready_i |=> m_tvalid_i, "result word dropped")
  `LPR_ASSERT(a_status_legal, m_tvalid_i |-> m_tuser_i <= lpr_pkg::ST_FULL, "bad status")
  `LPR_ASSERT(a_drop_zero, m_tvalid_i && m_tuser_i != lpr_pkg::ST_FORWARDED |-> m_tdata_i == 48'd0, "data on non-forwarded word")
  `LPR_ASSERT(a_fwd_ttl, m_tvalid_i && m_tuser_i == lpr_pkg::ST_FORWARDED |-> m_tdata_i[42:35] != 8'd0, "forwarded with zero TTL")

endmodule

bind ipv4_longest_prefix_router lpr_checker u_lpr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);
